[hw/rtl/egb_pkg.sv]
// ----------------------------------------------------------------------------
// egb_pkg
// Shared widths, microcode encoding and control structs of the extended
// Euclid block.
// ----------------------------------------------------------------------------
package egb_pkg;

  localparam int WIDTH     = 32;
  localparam int OPND_W    = 31;
  localparam int COEF_W    = 32;
  localparam int STEP_CAP  = (3 * WIDTH) / 2 + 4;
  localparam int STEP_W    = $clog2(STEP_CAP + 1);
  localparam int DIV_CNT_W = $clog2(OPND_W + 1);
  localparam int PC_W      = 3;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_IDLE     = 3'd0;
  localparam pc_t PC_TEST     = 3'd1;
  localparam pc_t PC_DIV_INIT = 3'd2;
  localparam pc_t PC_DIV_STEP = 3'd3;
  localparam pc_t PC_MUL_S    = 3'd4;
  localparam pc_t PC_UPD_S    = 3'd5;
  localparam pc_t PC_UPD_T    = 3'd6;
  localparam pc_t PC_EMIT     = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_S,
    OP_UPD_S,
    OP_UPD_T,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_WAIT_IN,
    JC_LOOP_END,
    JC_DIV_MORE,
    JC_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic step;
  } div_ctrl_t;

  typedef struct packed {
    logic last;
  } div_stat_t;

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t uc;
    case (pc)
      PC_IDLE:     uc = '{op: OP_LOAD,     cond: JC_WAIT_IN,  target: PC_IDLE};
      PC_TEST:     uc = '{op: OP_NOP,      cond: JC_LOOP_END, target: PC_EMIT};
      PC_DIV_INIT: uc = '{op: OP_DIV_INIT, cond: JC_NEXT,     target: PC_DIV_INIT};
      PC_DIV_STEP: uc = '{op: OP_DIV_STEP, cond: JC_DIV_MORE, target: PC_DIV_STEP};
      PC_MUL_S:    uc = '{op: OP_MUL_S,    cond: JC_NEXT,     target: PC_MUL_S};
      PC_UPD_S:    uc = '{op: OP_UPD_S,    cond: JC_NEXT,     target: PC_UPD_S};
      PC_UPD_T:    uc = '{op: OP_UPD_T,    cond: JC_ALWAYS,   target: PC_TEST};
      PC_EMIT:     uc = '{op: OP_EMIT,     cond: JC_OUT_BUSY, target: PC_EMIT};
      default:     uc = '{op: OP_NOP,      cond: JC_ALWAYS,   target: PC_IDLE};
    endcase
    return uc;
  endfunction

endpackage

[hw/rtl/egb_if.sv]
// ----------------------------------------------------------------------------
// egb_if
// Valid/ready channels for operand requests and gcd results.
// ----------------------------------------------------------------------------
interface egb_in_if;
  logic                       valid;
  logic                       ready;
  logic [egb_pkg::OPND_W-1:0] operand_a;
  logic [egb_pkg::OPND_W-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface egb_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [egb_pkg::COEF_W-1:0] coeff_x;
  logic signed [egb_pkg::COEF_W-1:0] coeff_y;
  logic        [egb_pkg::OPND_W-1:0] divisor;

  modport source (output valid, output coeff_x, output coeff_y, output divisor, input ready);
  modport sink   (input valid, input coeff_x, input coeff_y, input divisor, output ready);
endinterface

[hw/rtl/egb_divider.sv]
// ----------------------------------------------------------------------------
// egb_divider
// Restoring divider that produces one quotient bit per step.
// ----------------------------------------------------------------------------
module egb_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  egb_pkg::div_ctrl_t         ctrl,
  input  logic [egb_pkg::OPND_W-1:0] dividend,
  input  logic [egb_pkg::OPND_W-1:0] divisor_in,
  output logic [egb_pkg::OPND_W-1:0] quotient,
  output logic [egb_pkg::OPND_W-1:0] remainder,
  output egb_pkg::div_stat_t         stat
);

  logic [egb_pkg::OPND_W-1:0]    quo_r, quo_nxt;
  logic [egb_pkg::OPND_W-1:0]    rem_r, rem_nxt;
  logic [egb_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [egb_pkg::OPND_W:0]      trial;
  logic [egb_pkg::OPND_W:0]      diff;
  logic                          fits;

  always_comb begin
    trial   = {rem_r, quo_r[egb_pkg::OPND_W-1]};
    diff    = trial - {1'b0, divisor_in};
    fits    = (trial >= {1'b0, divisor_in});
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (ctrl.start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = egb_pkg::DIV_CNT_W'(egb_pkg::OPND_W);
    end else if (ctrl.step) begin
      quo_nxt = {quo_r[egb_pkg::OPND_W-2:0], fits};
      rem_nxt = fits ? diff[egb_pkg::OPND_W-1:0] : trial[egb_pkg::OPND_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat.last = (cnt_r == egb_pkg::DIV_CNT_W'(1));

endmodule

[hw/rtl/extended_gcd_bezout.sv]
// Each request runs n Euclid steps, n being at most 52 (45 for the worst 31-bit operands).
// Each step runs the loop test, the bit-serial divider (load and 31 quotient bits) and
// then the shared multiplier and the register updates.
// One request at a time; the next is accepted only after the result is emitted, and the
// emit step waits while the result channel still holds an unaccepted result.
// Reset is synchronous and active low; it returns the sequencer to idle.
// ----------------------------------------------------------------------------
// extended_gcd_bezout
// Microcoded extended Euclid unit returning gcd(a,b) and Bezout coefficients.
// ----------------------------------------------------------------------------
module extended_gcd_bezout (
  input  logic      clk,
  input  logic      rst_n,
  egb_in_if.sink    in_ch,
  egb_out_if.source out_ch
);

  egb_pkg::pc_t     pc_r, pc_nxt;
  egb_pkg::ucode_t  uc;
  logic             jump;
  logic             loop_end;
  logic             in_fire;
  logic             emit_go;
  logic             out_valid_r, out_valid_nxt;

  logic [egb_pkg::STEP_W-1:0] step_cnt_r, step_cnt_nxt;

  logic [egb_pkg::OPND_W-1:0] r_prev_r, r_cur_r;
  logic [egb_pkg::COEF_W-1:0] s_prev_r, s_cur_r, t_prev_r, t_cur_r;
  logic [egb_pkg::COEF_W-1:0] prod_r;
  logic [egb_pkg::COEF_W-1:0] mul_a, mul_b, mul_res;

  logic signed [egb_pkg::COEF_W-1:0] coeff_x_r, coeff_y_r;
  logic        [egb_pkg::OPND_W-1:0] divisor_r;

  egb_pkg::div_ctrl_t         div_ctrl;
  egb_pkg::div_stat_t         div_stat;
  logic [egb_pkg::OPND_W-1:0] div_quo, div_rem;

  assign uc       = egb_pkg::ucode_rom(pc_r);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign loop_end = (r_cur_r == '0) ||
                    (step_cnt_r == egb_pkg::STEP_W'(egb_pkg::STEP_CAP));
  assign emit_go  = (uc.op == egb_pkg::OP_EMIT) && !(out_valid_r && !out_ch.ready);

  always_comb begin
    case (uc.cond)
      egb_pkg::JC_NEXT:     jump = 1'b0;
      egb_pkg::JC_ALWAYS:   jump = 1'b1;
      egb_pkg::JC_WAIT_IN:  jump = !in_ch.valid;
      egb_pkg::JC_LOOP_END: jump = loop_end;
      egb_pkg::JC_DIV_MORE: jump = !div_stat.last;
      egb_pkg::JC_OUT_BUSY: jump = out_valid_r && !out_ch.ready;
      default:              jump = 1'b0;
    endcase
    pc_nxt = jump ? uc.target : pc_r + 1'b1;

    step_cnt_nxt = step_cnt_r;
    if (in_fire) begin
      step_cnt_nxt = '0;
    end else if (uc.op == egb_pkg::OP_UPD_T) begin
      step_cnt_nxt = step_cnt_r + 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= egb_pkg::PC_IDLE;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      step_cnt_r  <= step_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign div_ctrl.start = (uc.op == egb_pkg::OP_DIV_INIT);
  assign div_ctrl.step  = (uc.op == egb_pkg::OP_DIV_STEP);

  egb_divider u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (div_ctrl),
    .dividend   (r_prev_r),
    .divisor_in (r_cur_r),
    .quotient   (div_quo),
    .remainder  (div_rem),
    .stat       (div_stat)
  );

  assign mul_a   = egb_pkg::COEF_W'(div_quo);
  assign mul_b   = (uc.op == egb_pkg::OP_UPD_S) ? t_cur_r : s_cur_r;
  assign mul_res = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      r_prev_r <= in_ch.operand_a;
      r_cur_r  <= in_ch.operand_b;
      s_prev_r <= egb_pkg::COEF_W'(1);
      s_cur_r  <= '0;
      t_prev_r <= '0;
      t_cur_r  <= egb_pkg::COEF_W'(1);
    end
    case (uc.op)
      egb_pkg::OP_MUL_S: begin
        prod_r <= mul_res;
      end
      egb_pkg::OP_UPD_S: begin
        s_prev_r <= s_cur_r;
        s_cur_r  <= s_prev_r - prod_r;
        prod_r   <= mul_res;
      end
      egb_pkg::OP_UPD_T: begin
        t_prev_r <= t_cur_r;
        t_cur_r  <= t_prev_r - prod_r;
        r_prev_r <= r_cur_r;
        r_cur_r  <= div_rem;
      end
      default: begin
      end
    endcase
    if (emit_go) begin
      coeff_x_r <= s_prev_r;
      coeff_y_r <= t_prev_r;
      divisor_r <= r_prev_r;
    end
  end

  assign in_ch.ready    = (uc.op == egb_pkg::OP_LOAD);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.coeff_x = coeff_x_r;
  assign out_ch.coeff_y = coeff_y_r;
  assign out_ch.divisor = divisor_r;

`ifndef NO_ASSERTIONS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == egb_pkg::PC_MUL_S) |-> (div_rem < r_cur_r))
    else $error("Divider remainder not below divisor.");

  a_step_cap: assert property (@(posedge clk) disable iff (!rst_n)
    step_cnt_r <= egb_pkg::STEP_W'(egb_pkg::STEP_CAP))
    else $error("Euclid step count exceeds its cap.");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(pc_r) == egb_pkg::PC_EMIT))
    else $error("Result raised outside the emit step.");

  a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (pc_r == egb_pkg::PC_TEST) && (step_cnt_r == '0))
    else $error("Accepted request did not restart the sequence.");
`endif

endmodule
